FILE: hdl/rmp_pkg.sv
// Shared types and constants of the gradient ramp lookup unit.
`default_nettype none

package rmp_pkg;

   localparam int INDEX_W = 12;
   localparam int LEN_W = 13;
   localparam int COUNT_W = 3;
   localparam int POS_W = 17;
   localparam int COLOR_W = 32;
   localparam int STOP_W = POS_W + COLOR_W;
   localparam int PROD_W = POS_W + INDEX_W;
   localparam int POS_FRAC_W = 16;
   localparam int CH_W = 8;
   localparam int CHANNELS = 4;
   localparam int NUM_W = INDEX_W + CH_W;
   localparam int CSR_INDEX_W = 3;

   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 16;
   localparam int FRONT_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int BACK_CNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic [LEN_W-1:0] RAMP_LENGTH_RESET = LEN_W'(256);
   localparam logic [COLOR_W-1:0] START_COLOR_RESET = '0;
   localparam logic [COLOR_W-1:0] END_COLOR_RESET = '1;
   localparam logic [LEN_W-1:0] MIN_LENGTH = LEN_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RAMP_LENGTH,
      CSR_START_COLOR,
      CSR_END_COLOR,
      CSR_STOP_COUNT,
      CSR_STOP_ZERO,
      CSR_STOP_ONE,
      CSR_STOP_TWO,
      CSR_STOP_THREE
   } csr_index_type;

   typedef struct packed {
      logic [LEN_W-1:0]   ramp_length;
      logic [COLOR_W-1:0] start_color;
      logic [COLOR_W-1:0] end_color;
      logic [COUNT_W-1:0] stop_count;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_W-1:0] width;
      logic [INDEX_W-1:0] offset;
      logic [COLOR_W-1:0] left_color;
      logic [COLOR_W-1:0] right_color;
      logic               out_of_range;
   } seg_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] alpha;
      logic            out_of_range;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: hdl/rmp_queue.sv
// Small first-in first-out queue built from registers.
`default_nettype none

module rmp_queue #(
   parameter int DEPTH = 4,
   parameter type item_type = logic
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  item_type  push_item,
   input  wire logic pop,
   output logic      empty,
   output logic      full,
   output item_type  head
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign empty = (count_ff == '0);
   assign full = (count_ff == CNT_W'(DEPTH));
   assign head = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: hdl/rmp_front.sv
// Front end: places each stop on the ramp and finds the segment of the index.
`default_nettype none

module rmp_front #(
   parameter int MAX_STOPS = 4,
   parameter int MAX_LENGTH = 4096,
   parameter int STOP_SLOTS = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire logic [rmp_pkg::INDEX_W-1:0] in_index,
   input  rmp_pkg::cfg_type                 cfg,
   input  wire logic [rmp_pkg::STOP_W-1:0]  stops [STOP_SLOTS],
   output logic                             seg_valid,
   output rmp_pkg::seg_type                 seg
);
   import rmp_pkg::*;

   logic                 vld_ff, vld_in;
   logic [INDEX_W-1:0]   x_ff, x_in;
   logic [INDEX_W-1:0]   last_ff, last_in;
   logic                 oor_ff, oor_in;
   logic [LEN_W-1:0]     h_raw_ff [STOP_SLOTS];
   logic [LEN_W-1:0]     h_raw_in [STOP_SLOTS];
   logic [LEN_W-1:0]     eff_len;
   logic [PROD_W-1:0]    prod;

   logic                 seg_vld_ff, seg_vld_in;
   seg_type              seg_ff, seg_in;
   logic [COUNT_W-1:0]   count;
   logic [INDEX_W-1:0]   h_clamp;
   logic [INDEX_W-1:0]   prev_h;
   logic [INDEX_W-1:0]   right_pt [STOP_SLOTS+1];
   logic [COLOR_W-1:0]   right_col [STOP_SLOTS+1];
   logic [INDEX_W-1:0]   left_pt;
   logic [COLOR_W-1:0]   left_col;

   always_comb begin
      eff_len = cfg.ramp_length;
      if (eff_len < MIN_LENGTH) begin
         eff_len = MIN_LENGTH;
      end
      if (eff_len > LEN_W'(MAX_LENGTH)) begin
         eff_len = LEN_W'(MAX_LENGTH);
      end
      last_in = INDEX_W'(eff_len - LEN_W'(1));
      x_in = in_index;
      oor_in = (LEN_W'(in_index) >= eff_len);
      vld_in = in_valid;
      prod = '0;
      for (int k = 0; k < STOP_SLOTS; k++) begin
         prod = PROD_W'(stops[k][POS_W-1:0]) * PROD_W'(last_in);
         h_raw_in[k] = prod[PROD_W-1:POS_FRAC_W];
      end
   end

   always_comb begin
      count = (int'(cfg.stop_count) > MAX_STOPS) ? COUNT_W'(MAX_STOPS) : cfg.stop_count;
      prev_h = '0;
      h_clamp = '0;
      for (int k = 0; k < STOP_SLOTS; k++) begin
         h_clamp = (h_raw_ff[k] > LEN_W'(last_ff)) ? last_ff : h_raw_ff[k][INDEX_W-1:0];
         if (h_clamp < prev_h) begin
            h_clamp = prev_h;
         end
         prev_h = h_clamp;
         if (int'(count) > k) begin
            right_pt[k] = h_clamp;
            right_col[k] = stops[k][STOP_W-1:POS_W];
         end else begin
            right_pt[k] = last_ff;
            right_col[k] = cfg.end_color;
         end
      end
      right_pt[STOP_SLOTS] = last_ff;
      right_col[STOP_SLOTS] = cfg.end_color;

      seg_in.width = INDEX_W'(1);
      seg_in.offset = '0;
      seg_in.left_color = cfg.end_color;
      seg_in.right_color = cfg.end_color;
      seg_in.out_of_range = oor_ff;
      left_pt = '0;
      left_col = cfg.start_color;
      for (int i = STOP_SLOTS; i >= 0; i--) begin
         left_pt = (i == 0) ? '0 : right_pt[(i == 0) ? 0 : i - 1];
         left_col = (i == 0) ? cfg.start_color : right_col[(i == 0) ? 0 : i - 1];
         if (!oor_ff && x_ff < right_pt[i]) begin
            seg_in.width = right_pt[i] - left_pt;
            seg_in.offset = x_ff - left_pt;
            seg_in.left_color = left_col;
            seg_in.right_color = right_col[i];
         end
      end
      seg_vld_in = vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         seg_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         seg_vld_ff <= seg_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      last_ff <= last_in;
      oor_ff <= oor_in;
      h_raw_ff <= h_raw_in;
      seg_ff <= seg_in;
   end

   assign seg_valid = seg_vld_ff;
   assign seg = seg_ff;

endmodule

`default_nettype wire

FILE: hdl/rmp_back.sv
// Back end: weights the two segment colors and divides by the segment width.
`default_nettype none

module rmp_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  rmp_pkg::seg_type   seg,
   output logic               out_valid,
   output rmp_pkg::rsp_item_type out_item
);
   import rmp_pkg::*;

   localparam int DIV_STEPS = CH_W;

   typedef struct packed {
      logic [CHANNELS-1:0][NUM_W-1:0] rem;
      logic [CHANNELS-1:0][CH_W-1:0]  quo;
      logic [INDEX_W-1:0]             width;
      logic                           out_of_range;
   } div_stage_type;

   div_stage_type      stage_ff [DIV_STEPS+1];
   div_stage_type      stage_in [DIV_STEPS+1];
   logic               vld_ff [DIV_STEPS+1];
   logic               vld_in [DIV_STEPS+1];
   logic [INDEX_W-1:0] inv_offset;
   logic [NUM_W:0]     sum;
   logic [NUM_W-1:0]   trial;

   always_comb begin
      inv_offset = seg.width - seg.offset;
      sum = '0;
      trial = '0;
      stage_in[0].width = seg.width;
      stage_in[0].out_of_range = seg.out_of_range;
      stage_in[0].quo = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         sum = (NUM_W+1)'(inv_offset) * (NUM_W+1)'(seg.left_color[c*CH_W +: CH_W])
             + (NUM_W+1)'(seg.offset) * (NUM_W+1)'(seg.right_color[c*CH_W +: CH_W]);
         stage_in[0].rem[c] = sum[NUM_W-1:0];
      end
      vld_in[0] = in_valid;
      for (int s = 0; s < DIV_STEPS; s++) begin
         stage_in[s+1] = stage_ff[s];
         vld_in[s+1] = vld_ff[s];
         for (int c = 0; c < CHANNELS; c++) begin
            trial = NUM_W'(stage_ff[s].width) << (DIV_STEPS - 1 - s);
            if (stage_ff[s].rem[c] >= trial) begin
               stage_in[s+1].rem[c] = stage_ff[s].rem[c] - trial;
               stage_in[s+1].quo[c][DIV_STEPS-1-s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STEPS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = vld_ff[DIV_STEPS];
   assign out_item.red = stage_ff[DIV_STEPS].quo[0];
   assign out_item.green = stage_ff[DIV_STEPS].quo[1];
   assign out_item.blue = stage_ff[DIV_STEPS].quo[2];
   assign out_item.alpha = stage_ff[DIV_STEPS].quo[3];
   assign out_item.out_of_range = stage_ff[DIV_STEPS].out_of_range;

endmodule

`default_nettype wire

FILE: hdl/multi_stop_gradient_ramp_unit.sv
// A request passes through the front end, the segment queue, the back end and the result queue.
// Throughput: one request per cycle while req_full is low, held by credit counters over the 4-entry
// segment queue and the 16-entry result queue.
// The back end spends one multiply stage and eight one-bit divide stages.
// Reset is synchronous: it empties both queues and the pipelines and loads
// every configuration register with its default.
`default_nettype none

module multi_stop_gradient_ramp_unit #(
   parameter int MAX_STOPS = 4,
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [rmp_pkg::INDEX_W-1:0] req_texel_index,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic [rmp_pkg::CH_W-1:0]         rsp_red,
   output logic [rmp_pkg::CH_W-1:0]         rsp_green,
   output logic [rmp_pkg::CH_W-1:0]         rsp_blue,
   output logic [rmp_pkg::CH_W-1:0]         rsp_alpha,
   output logic                             rsp_out_of_range,
   input  wire logic                        csr_write_enable,
   input  rmp_pkg::csr_index_type           csr_index,
   input  wire logic [rmp_pkg::STOP_W-1:0]  csr_write_data
);
   import rmp_pkg::*;

   localparam int STOP_SLOTS = (MAX_STOPS > 0) ? MAX_STOPS : 1;

   cfg_type                 cfg_ff, cfg_in;
   logic [STOP_W-1:0]       stop_ff [STOP_SLOTS];
   logic [STOP_W-1:0]       stop_in [STOP_SLOTS];
   logic [FRONT_CNT_W-1:0]  front_used_ff, front_used_in;
   logic [BACK_CNT_W-1:0]   back_used_ff, back_used_in;

   logic          req_accept;
   logic          rsp_accept;
   logic          seg_valid;
   seg_type       seg;
   logic          mid_empty, mid_full, mid_pop;
   seg_type       mid_head;
   logic          out_valid;
   rsp_item_type  out_item;
   logic          out_empty, out_full;
   rsp_item_type  out_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RAMP_LENGTH: cfg_in.ramp_length = csr_write_data[LEN_W-1:0];
            CSR_START_COLOR: cfg_in.start_color = csr_write_data[COLOR_W-1:0];
            CSR_END_COLOR:   cfg_in.end_color = csr_write_data[COLOR_W-1:0];
            CSR_STOP_COUNT:  cfg_in.stop_count = csr_write_data[COUNT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
      for (int k = 0; k < STOP_SLOTS; k++) begin
         stop_in[k] = stop_ff[k];
         if (csr_write_enable && int'(csr_index) == int'(CSR_STOP_ZERO) + k) begin
            stop_in[k] = csr_write_data;
         end
      end
   end

   assign req_accept = req_push && !req_full;
   assign rsp_accept = rsp_pop && !rsp_empty;
   assign req_full = (front_used_ff == FRONT_CNT_W'(MID_DEPTH));
   assign mid_pop = !mid_empty && (back_used_ff != BACK_CNT_W'(OUT_DEPTH));

   always_comb begin
      front_used_in = front_used_ff + FRONT_CNT_W'(req_accept) - FRONT_CNT_W'(mid_pop);
      back_used_in = back_used_ff + BACK_CNT_W'(mid_pop) - BACK_CNT_W'(rsp_accept);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_length <= RAMP_LENGTH_RESET;
         cfg_ff.start_color <= START_COLOR_RESET;
         cfg_ff.end_color <= END_COLOR_RESET;
         cfg_ff.stop_count <= '0;
         for (int k = 0; k < STOP_SLOTS; k++) begin
            stop_ff[k] <= '0;
         end
         front_used_ff <= '0;
         back_used_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
         stop_ff <= stop_in;
         front_used_ff <= front_used_in;
         back_used_ff <= back_used_in;
      end
   end

   rmp_front #(
      .MAX_STOPS  (MAX_STOPS),
      .MAX_LENGTH (MAX_LENGTH),
      .STOP_SLOTS (STOP_SLOTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_index  (req_texel_index),
      .cfg       (cfg_ff),
      .stops     (stop_ff),
      .seg_valid (seg_valid),
      .seg       (seg)
   );

   rmp_queue #(
      .DEPTH     (MID_DEPTH),
      .item_type (seg_type)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_valid),
      .push_item (seg),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .full      (mid_full),
      .head      (mid_head)
   );

   rmp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_pop),
      .seg       (mid_head),
      .out_valid (out_valid),
      .out_item  (out_item)
   );

   rmp_queue #(
      .DEPTH     (OUT_DEPTH),
      .item_type (rsp_item_type)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_valid),
      .push_item (out_item),
      .pop       (rsp_accept),
      .empty     (out_empty),
      .full      (out_full),
      .head      (out_head)
   );

   assign rsp_empty = out_empty;
   assign rsp_red = out_head.red;
   assign rsp_green = out_head.green;
   assign rsp_blue = out_head.blue;
   assign rsp_alpha = out_head.alpha;
   assign rsp_out_of_range = out_head.out_of_range;

`ifndef SYNTH
   a_front_credit: assert property (@(posedge clock) disable iff (reset)
      front_used_ff <= FRONT_CNT_W'(MID_DEPTH))
      else $error("Front credit count exceeds the segment queue depth.");

   a_back_credit: assert property (@(posedge clock) disable iff (reset)
      back_used_ff <= BACK_CNT_W'(OUT_DEPTH))
      else $error("Back credit count exceeds the result queue depth.");

   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      seg_valid |-> !mid_full || mid_pop)
      else $error("Segment queue written while full.");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> !out_full || rsp_accept)
      else $error("Result queue written while full.");
`endif

endmodule

`default_nettype wire
